FILE: rtl/core/hrbe_pkg.sv
// shared types, constants and helpers for the response body extractor
`default_nettype none
package hrbe_pkg;
    localparam int LENGTH_BITS = 32;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    typedef enum logic [3:0] {
        PH_S_NAME = 4'd0, PH_S_VER = 4'd1, PH_S_DIG = 4'd2, PH_S_TEXT = 4'd3,
        PH_S_BAD = 4'd4, PH_H_KEY = 4'd5, PH_H_SKIP = 4'd6, PH_H_TE = 4'd7,
        PH_H_CL = 4'd8, PH_B_LEN = 4'd9, PH_B_PASS = 4'd10, PH_C_SIZE = 4'd11,
        PH_C_DATA = 4'd12, PH_C_TRAIL = 4'd13
    } t_phase;

    localparam logic [2:0] EV_BODY = 3'd0;
    localparam logic [2:0] EV_DONE = 3'd1;
    localparam logic [2:0] EV_STATUS = 3'd2;
    localparam logic [2:0] EV_BADLINE = 3'd3;
    localparam logic [2:0] EV_NOCOLON = 3'd4;
    localparam logic [2:0] EV_BADNUM = 3'd5;

    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_PLUS = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam logic [4:0] TE_LEN = 5'd17;
    localparam logic [4:0] CL_LEN = 5'd14;
    localparam logic [2:0] CK_LEN = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_message;
        logic       segment_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] body_byte;
        logic [2:0] event_res;
        logic [9:0] status_code;
    } t_out_item;

    function automatic logic [7:0] te_char(input logic [4:0] p);
        logic [7:0] c;
        unique case (p)
            5'd0: c = "t"; 5'd1: c = "r"; 5'd2: c = "a"; 5'd3: c = "n";
            5'd4: c = "s"; 5'd5: c = "f"; 5'd6: c = "e"; 5'd7: c = "r";
            5'd8: c = "-"; 5'd9: c = "e"; 5'd10: c = "n"; 5'd11: c = "c";
            5'd12: c = "o"; 5'd13: c = "d"; 5'd14: c = "i"; 5'd15: c = "n";
            5'd16: c = "g";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cl_char(input logic [4:0] p);
        logic [7:0] c;
        unique case (p)
            5'd0: c = "c"; 5'd1: c = "o"; 5'd2: c = "n"; 5'd3: c = "t";
            5'd4: c = "e"; 5'd5: c = "n"; 5'd6: c = "t"; 5'd7: c = "-";
            5'd8: c = "l"; 5'd9: c = "e"; 5'd10: c = "n"; 5'd11: c = "g";
            5'd12: c = "t"; 5'd13: c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ck_char(input logic [2:0] p);
        logic [7:0] c;
        unique case (p)
            3'd0: c = "c"; 3'd1: c = "h"; 3'd2: c = "u"; 3'd3: c = "n";
            3'd4: c = "k"; 3'd5: c = "e"; 3'd6: c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_dig(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/hrbe_acc.sv
// saturating decimal and hex accumulate for the length counter
`default_nettype none
module hrbe_acc (
    input  wire logic [hrbe_pkg::LENGTH_BITS-1:0] i_value,
    input  wire logic [7:0]                       i_byte,
    output logic [hrbe_pkg::LENGTH_BITS-1:0]      o_dec,
    output logic [hrbe_pkg::LENGTH_BITS-1:0]      o_hex,
    output logic                                  o_hex_ok
);
    import hrbe_pkg::*;
    logic [3:0] w_dig;
    logic [3:0] w_hd;
    logic [LENGTH_BITS+3:0] w_d10;
    logic [LENGTH_BITS+3:0] w_h16;

    always_comb begin
        w_dig = 4'(i_byte - "0");
        o_hex_ok = 1'b1;
        if (is_dig(i_byte)) begin
            w_hd = 4'(i_byte - "0");
        end else if (i_byte >= "a" && i_byte <= "f") begin
            w_hd = 4'(i_byte - "a" + 8'd10);
        end else if (i_byte >= "A" && i_byte <= "F") begin
            w_hd = 4'(i_byte - "A" + 8'd10);
        end else begin
            w_hd = 4'd0;
            o_hex_ok = 1'b0;
        end
        // x*10 = x*8 + x*2, wide enough to see overflow
        w_d10 = ({4'd0, i_value} << 3) + ({4'd0, i_value} << 1)
              + {{LENGTH_BITS{1'b0}}, w_dig};
        w_h16 = {i_value, 4'd0} + {{LENGTH_BITS{1'b0}}, w_hd};
        o_dec = (w_d10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? LEN_MAX
              : w_d10[LENGTH_BITS-1:0];
        o_hex = (i_value[LENGTH_BITS-1:LENGTH_BITS-4] != 4'd0) ? LEN_MAX
              : w_h16[LENGTH_BITS-1:0];
    end
endmodule
`default_nettype wire

FILE: rtl/core/http_response_body_extractor.sv
// top level: byte-wide response parser with registered output
// the result of an input transaction is held in the output register in the cycle after it
// throughput: one byte per cycle while o_stall is low, set by the single-pass parser step
// a held result stalls input only when the output register cannot drain
// synchronous active-low reset returns the parser to the start of a status line
`default_nettype none
module http_response_body_extractor (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire hrbe_pkg::t_in_item   i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output hrbe_pkg::t_out_item       o_data
);
    import hrbe_pkg::*;

    t_phase r_phase, n_phase;
    logic [9:0] r_status, n_status;
    logic [1:0] r_lbc, n_lbc;
    logic [4:0] r_kmp, n_kmp;
    logic [1:0] r_kc, n_kc;
    logic [2:0] r_cmp, n_cmp;
    logic r_chunked, n_chunked;
    logic r_len_known, n_len_known;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic r_fin, n_fin;
    logic r_ovalid;
    t_out_item r_out;

    logic       w_emit;
    logic [7:0] w_ebyte;
    logic [2:0] w_ev;
    logic [LENGTH_BITS-1:0] w_dec, w_hex, w_acc_in;
    logic w_hex_ok;
    logic w_take;
    logic [7:0] b, c;
    logic [13:0] w_s10;

    assign o_stall = r_ovalid && i_stall;
    assign w_take = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_data = r_out;
    assign b = i_data.data_byte;

    // after a start of message the accumulator begins from zero
    assign w_acc_in = i_data.start_of_message ? '0 : r_rem;

    hrbe_acc u_acc (
        .i_value(w_acc_in), .i_byte(b), .o_dec(w_dec), .o_hex(w_hex), .o_hex_ok(w_hex_ok)
    );

    always_comb begin
        logic [4:0] p;
        logic [2:0] st;
        n_phase = r_phase; n_status = r_status; n_lbc = r_lbc; n_kmp = r_kmp;
        n_kc = r_kc; n_cmp = r_cmp; n_chunked = r_chunked; n_len_known = r_len_known;
        n_rem = r_rem; n_fin = r_fin;
        w_emit = 1'b0; w_ebyte = 8'd0; w_ev = EV_BODY;
        p = 5'd0; st = 3'd0;
        c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (i_data.start_of_message) begin
            n_phase = PH_S_NAME; n_status = '0; n_lbc = '0; n_kmp = '0; n_kc = 2'b11;
            n_cmp = '0; n_chunked = 1'b0; n_len_known = 1'b0; n_rem = '0; n_fin = 1'b0;
        end
        w_s10 = {4'd0, n_status} * 14'd10 + {10'd0, 4'(b - "0")};
        if (!n_fin) begin
            if (n_phase <= PH_S_BAD) begin
                if (b == CH_LF) begin
                    if (n_phase != PH_S_TEXT || !n_lbc[0]) begin
                        n_fin = 1'b1; w_emit = 1'b1; w_ev = EV_BADLINE;
                    end else if (n_status != 10'd200) begin
                        n_fin = 1'b1; w_emit = 1'b1; w_ev = EV_STATUS;
                    end else begin
                        n_phase = PH_H_KEY; n_lbc = '0; n_kmp = '0; n_kc = 2'b11;
                        n_cmp = '0;
                    end
                end else begin
                    unique case (n_phase)
                        PH_S_NAME: begin
                            if (b == CH_SLASH) begin
                                n_phase = n_lbc[0] ? PH_S_VER : PH_S_BAD;
                                if (n_lbc[0]) n_lbc = '0;
                            end else n_lbc = 2'd1;
                        end
                        PH_S_VER: begin
                            if (b == CH_SP) begin
                                n_phase = n_lbc[0] ? PH_S_DIG : PH_S_BAD;
                                n_lbc = '0;
                            end else n_lbc = 2'd1;
                        end
                        PH_S_DIG: begin
                            if (is_dig(b)) begin
                                n_status = (w_s10 > 14'd999) ? 10'd999 : w_s10[9:0];
                                n_lbc = 2'd1;
                            end else if (b == CH_SP && n_lbc[0]) begin
                                n_phase = PH_S_TEXT; n_lbc = '0;
                            end else n_phase = PH_S_BAD;
                        end
                        PH_S_TEXT: begin
                            if (n_lbc[1]) n_phase = PH_S_BAD;
                            else if (b == CH_CR) n_lbc[1] = 1'b1;
                            else n_lbc[0] = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end else if (n_phase <= PH_H_CL) begin
                if (b == CH_LF) begin
                    if (n_lbc <= 2'd2) begin
                        if (n_len_known) begin
                            if (n_rem == '0) begin
                                n_fin = 1'b1; w_emit = 1'b1; w_ev = EV_DONE;
                            end else n_phase = PH_B_LEN;
                        end else if (n_chunked) begin
                            n_phase = PH_C_SIZE; n_kmp = '0; n_rem = '0;
                        end else n_phase = PH_B_PASS;
                    end else if (n_phase == PH_H_KEY) begin
                        n_fin = 1'b1; w_emit = 1'b1; w_ev = EV_NOCOLON;
                    end else if (n_phase == PH_H_CL && n_kmp != 5'd2 && n_kmp != 5'd3) begin
                        n_fin = 1'b1; w_emit = 1'b1; w_ev = EV_BADNUM;
                    end else begin
                        if (n_phase == PH_H_TE) n_chunked = (n_cmp == CK_LEN);
                        if (n_phase == PH_H_CL)
                            n_len_known = !((n_cmp != 3'd0) && (n_rem != '0));
                        n_phase = PH_H_KEY; n_lbc = '0; n_kmp = '0; n_kc = 2'b11;
                        n_cmp = '0;
                    end
                end else begin
                    if (n_lbc < 2'd3) n_lbc = n_lbc + 2'd1;
                    priority case (n_phase)
                        PH_H_KEY: begin
                            if (b == CH_COLON) begin
                                if (n_kc[0] && n_kmp == TE_LEN) begin
                                    n_phase = PH_H_TE; n_cmp = '0;
                                end else if (n_kc[1] && n_kmp == CL_LEN) begin
                                    n_phase = PH_H_CL; n_kmp = '0; n_cmp = '0; n_rem = '0;
                                end else n_phase = PH_H_SKIP;
                            end else begin
                                p = n_kmp;
                                if (p >= TE_LEN || c != te_char(p)) n_kc[0] = 1'b0;
                                if (p >= CL_LEN || c != cl_char(p)) n_kc[1] = 1'b0;
                                if (n_kmp < 5'd31) n_kmp = n_kmp + 5'd1;
                            end
                        end
                        PH_H_TE: begin
                            if (n_cmp < CK_LEN) begin
                                if (b == ck_char(n_cmp)) n_cmp = n_cmp + 3'd1;
                                else n_cmp = (b == "c") ? 3'd1 : 3'd0;
                            end
                        end
                        PH_H_CL: begin
                            unique case (n_kmp)
                                5'd0: begin
                                    if (!is_ws(b)) begin
                                        if (b == CH_PLUS || b == CH_MINUS) begin
                                            if (b == CH_MINUS) n_cmp = 3'd1;
                                            n_kmp = 5'd1;
                                        end else if (is_dig(b)) begin
                                            n_rem = w_dec; n_kmp = 5'd2;
                                        end else n_kmp = 5'd4;
                                    end
                                end
                                5'd1: begin
                                    if (is_dig(b)) begin
                                        n_rem = w_dec; n_kmp = 5'd2;
                                    end else n_kmp = 5'd4;
                                end
                                5'd2: begin
                                    if (is_dig(b)) n_rem = w_dec;
                                    else n_kmp = 5'd3;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end else begin
                unique case (n_phase)
                    PH_B_LEN: begin
                        if (n_rem == '0) begin
                            n_fin = 1'b1; w_emit = 1'b1; w_ev = EV_DONE;
                        end else begin
                            n_rem = n_rem - 1'b1; w_emit = 1'b1; w_ebyte = b;
                        end
                    end
                    PH_B_PASS: begin
                        w_emit = 1'b1; w_ebyte = b;
                    end
                    PH_C_SIZE: begin
                        st = n_kmp[2:0];
                        if (b == CH_LF) begin
                            if (st == 3'd0 || st == 3'd5) begin
                                n_fin = 1'b1; w_emit = 1'b1; w_ev = EV_DONE;
                            end else if (st == 3'd2 || st == 3'd3) begin
                                if (n_rem == '0) begin
                                    n_fin = 1'b1; w_emit = 1'b1; w_ev = EV_DONE;
                                end else n_phase = PH_C_DATA;
                            end else begin
                                n_fin = 1'b1; w_emit = 1'b1; w_ev = EV_BADNUM;
                            end
                        end else if (st == 3'd0 && b == CH_CR) begin
                            n_kmp = 5'd5;
                        end else begin
                            if (st == 3'd0 || st == 3'd5) st = 3'd1;
                            if (st == 3'd1) begin
                                if (w_hex_ok) begin
                                    n_rem = w_hex; st = 3'd2;
                                end else if (!is_ws(b)) st = 3'd4;
                            end else if (st == 3'd2) begin
                                if (w_hex_ok) n_rem = w_hex;
                                else st = 3'd3;
                            end
                            n_kmp = {2'd0, st};
                        end
                    end
                    PH_C_DATA: begin
                        if (n_rem != '0) n_rem = n_rem - 1'b1;
                        if (n_rem == '0) n_phase = PH_C_TRAIL;
                        w_emit = 1'b1; w_ebyte = b;
                    end
                    PH_C_TRAIL: begin
                        if (b == CH_LF) begin
                            n_phase = PH_C_SIZE; n_kmp = '0; n_rem = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_S_NAME; r_status <= '0; r_lbc <= '0; r_kmp <= '0;
            r_kc <= 2'b11; r_cmp <= '0; r_chunked <= 1'b0; r_len_known <= 1'b0;
            r_rem <= '0; r_fin <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (w_take) begin
                r_phase <= n_phase; r_status <= n_status; r_lbc <= n_lbc; r_kmp <= n_kmp;
                r_kc <= n_kc; r_cmp <= n_cmp; r_chunked <= n_chunked;
                r_len_known <= n_len_known; r_rem <= n_rem; r_fin <= n_fin;
            end
            if (w_take) r_ovalid <= w_emit;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_out.body_byte <= w_ebyte;
            r_out.event_res <= w_ev;
            r_out.status_code <= n_status;
        end
    end
endmodule
`default_nettype wire
